// ===== rtl/cfm_pkg.sv =====
// Shared types, constants and elaboration-time gamma threshold table for the cross-fade pixel unit.
package cfm_pkg;

    // Default fixed-point settings.
    localparam int FRAC_BITS_DEF        = 12;
    localparam int GAMMA_INDEX_BITS_DEF = 12;

    // Field widths fixed by the pixel format.
    localparam int PIX_W      = 16;
    localparam int OUT_W      = 8;
    localparam int MIX_W      = 13;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Number of binary-search steps over the 8-bit output code.
    localparam int SRCH_STEPS = OUT_W;
    localparam int OUT_CODES  = 1 << OUT_W;

    // Threshold entries hold gamma indexes of up to 15 bits.
    localparam int THR_W = 15;
    localparam int BIG_W = 192;

    // Register reset values.
    localparam logic [MIX_W-1:0]  MIX_RST  = '0;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd4096;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIX_WEIGHT    = 2'd0,
        CFG_EXPOSURE_GAIN = 2'd1
    } t_cfg_idx;

    // Flow status from the pipeline control to the top level.
    typedef struct packed {
        logic in_ready;
        logic out_valid;
    } t_flow;

    // Smallest gamma index that reaches each output code.
    typedef logic [OUT_CODES-1:0][THR_W-1:0] t_thr_tab;

    // Integer power on wide values, used only at elaboration.
    function automatic logic [BIG_W-1:0] big_pow(logic [BIG_W-1:0] base, int expo);
        logic [BIG_W-1:0] acc;
        acc = BIG_W'(1);
        for (int k = 0; k < expo; k++) begin
            acc = acc * base;
        end
        return acc;
    endfunction

    // Code v is reached at index i when i^5 * 510^11 >= (2v-1)^11 * (2^G)^5.
    // The threshold for each code is found by a binary search over the index.
    function automatic t_thr_tab gamma_thr_tab(int gbits);
        t_thr_tab         tab;
        logic [BIG_W-1:0] p510;
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        int               lo;
        int               hi;
        int               mid;
        tab  = '0;
        p510 = big_pow(BIG_W'(510), 11);
        for (int v = 1; v < OUT_CODES; v++) begin
            rhs = big_pow(BIG_W'(2 * v - 1), 11) << (5 * gbits);
            lo  = 0;
            hi  = 1 << gbits;
            for (int it = 0; it < THR_W + 1; it++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    lhs = big_pow(BIG_W'(mid), 5) * p510;
                    if (lhs >= rhs) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1;
                    end
                end
            end
            tab[v] = THR_W'(lo);
        end
        return tab;
    endfunction

endpackage

// ===== rtl/cfm_ifs.sv =====
// Valid/ready channel interfaces for pixels in, pixels out and register writes.
interface cfm_pix_in_if;
    import cfm_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] src_red;
    logic [PIX_W-1:0] src_green;
    logic [PIX_W-1:0] src_blue;
    logic [PIX_W-1:0] inc_red;
    logic [PIX_W-1:0] inc_green;
    logic [PIX_W-1:0] inc_blue;

    modport source (output valid, src_red, src_green, src_blue,
                    inc_red, inc_green, inc_blue, input ready);
    modport sink (input valid, src_red, src_green, src_blue,
                  inc_red, inc_green, inc_blue, output ready);
endinterface

interface cfm_pix_out_if;
    import cfm_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] out_red;
    logic [OUT_W-1:0] out_green;
    logic [OUT_W-1:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface cfm_cfg_if;
    import cfm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink (input valid, idx, data, output ready);
endinterface

// ===== rtl/crossfade_tone_map_gamma_pixel_unit.sv =====
// Top level: configuration registers, three color lanes and the output merge.
//
// Usage: pixels enter on i_pix as a source and an incoming linear RGB triple
// (unsigned Q4.12). Each beat on o_pix carries the three gamma-encoded 8-bit
// codes of one pixel, in input order. Register writes arrive on i_cfg: index 0
// is the cross-fade weight, index 1 the exposure gain; other indexes are
// dropped. i_cfg is always ready. Write registers only while no pixel is in
// flight.
// Between input beat and output beat lie one stage for the cross-fade, one
// for the tone-map operands, FRAC_BITS + 1 stages of the bit-per-stage
// divider, one for exposure and eight for the gamma code search.
// Throughput is one pixel per cycle while o_pix is ready; the three lanes share one stage control.
// When o_pix stalls, stages fill up behind the output register and i_pix
// stays ready until every stage holds a pixel.
// Reset clears all stage valid bits, sets the weight to 0 and the gain to
// 1.0; pixels in flight are dropped.
module crossfade_tone_map_gamma_pixel_unit #(
    parameter int FRAC_BITS        = cfm_pkg::FRAC_BITS_DEF,
    parameter int GAMMA_INDEX_BITS = cfm_pkg::GAMMA_INDEX_BITS_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    cfm_pix_in_if.sink    i_pix,
    cfm_pix_out_if.source o_pix,
    cfm_cfg_if.sink       i_cfg
);
    import cfm_pkg::*;

    localparam int NUM_STAGES = FRAC_BITS + 12;
    localparam int OW         = FRAC_BITS + 1;
    localparam logic [OW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Configuration registers.
    logic [MIX_W-1:0]  r_mix_weight;
    logic [GAIN_W-1:0] r_exp_gain;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_weight <= MIX_RST;
            r_exp_gain   <= GAIN_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                CFG_MIX_WEIGHT:    r_mix_weight <= i_cfg.data[MIX_W-1:0];
                CFG_EXPOSURE_GAIN: r_exp_gain   <= i_cfg.data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Weight saturates at one.
    logic [OW-1:0] weight;
    assign weight = (32'(r_mix_weight) >= 32'(ONE)) ? ONE : OW'(r_mix_weight);

    // Shared stage control.
    logic [NUM_STAGES-1:0] en;
    t_flow                 flow;

    cfm_pipe_ctrl #(
        .NUM_STAGES (NUM_STAGES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_pix.valid),
        .i_out_ready (o_pix.ready),
        .o_en        (en),
        .o_flow      (flow)
    );

    assign i_pix.ready = flow.in_ready;
    assign o_pix.valid = flow.out_valid;

    // One lane per color.
    logic [OUT_W-1:0] red_val;
    logic [OUT_W-1:0] green_val;
    logic [OUT_W-1:0] blue_val;

    cfm_lane #(
        .FRAC_BITS        (FRAC_BITS),
        .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS),
        .NUM_STAGES       (NUM_STAGES)
    ) u_lane_red (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_weight (weight),
        .i_gain   (r_exp_gain),
        .i_src    (i_pix.src_red),
        .i_inc    (i_pix.inc_red),
        .o_val    (red_val)
    );

    cfm_lane #(
        .FRAC_BITS        (FRAC_BITS),
        .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS),
        .NUM_STAGES       (NUM_STAGES)
    ) u_lane_green (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_weight (weight),
        .i_gain   (r_exp_gain),
        .i_src    (i_pix.src_green),
        .i_inc    (i_pix.inc_green),
        .o_val    (green_val)
    );

    cfm_lane #(
        .FRAC_BITS        (FRAC_BITS),
        .GAMMA_INDEX_BITS (GAMMA_INDEX_BITS),
        .NUM_STAGES       (NUM_STAGES)
    ) u_lane_blue (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_weight (weight),
        .i_gain   (r_exp_gain),
        .i_src    (i_pix.src_blue),
        .i_inc    (i_pix.inc_blue),
        .o_val    (blue_val)
    );

    // Merge the lane results into one output beat.
    assign o_pix.out_red   = red_val;
    assign o_pix.out_green = green_val;
    assign o_pix.out_blue  = blue_val;

`ifndef SYNTHESIS
    // An empty output stage leaves room for a new pixel.
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pix.valid |-> i_pix.ready)
        else $error("input not ready with empty output stage");

    // A ready receiver lets the whole pipeline advance.
    a_ready_follows_sink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.ready |-> i_pix.ready)
        else $error("input not ready while receiver is ready");

    // No output beat right after reset.
    a_no_out_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_pix.valid)
        else $error("output valid right after reset");
`endif

endmodule

// ===== rtl/cfm_pipe_ctrl.sv =====
// Stage valid bits and per-stage advance enables shared by all color lanes.
module cfm_pipe_ctrl #(
    parameter int NUM_STAGES = cfm_pkg::FRAC_BITS_DEF + 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_out_ready,
    output logic [NUM_STAGES-1:0] o_en,
    output cfm_pkg::t_flow        o_flow
);
    import cfm_pkg::*;

    logic [NUM_STAGES-1:0] r_v;

    // A stage may load when it is empty or when the stage after it moves too.
    assign o_en[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || i_out_ready;
    for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
        assign o_en[k] = !r_v[k] || o_en[k+1];
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (o_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (o_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_flow.in_ready  = o_en[0];
    assign o_flow.out_valid = r_v[NUM_STAGES-1];

endmodule

// ===== rtl/cfm_lane.sv =====
// One color channel: cross-fade, tone-map divider, exposure, gamma code search.
module cfm_lane #(
    parameter int FRAC_BITS        = cfm_pkg::FRAC_BITS_DEF,
    parameter int GAMMA_INDEX_BITS = cfm_pkg::GAMMA_INDEX_BITS_DEF,
    parameter int NUM_STAGES       = cfm_pkg::FRAC_BITS_DEF + 12
) (
    input  logic                       i_clk,
    input  logic [NUM_STAGES-1:0]      i_en,
    input  logic [FRAC_BITS:0]         i_weight,
    input  logic [cfm_pkg::GAIN_W-1:0] i_gain,
    input  logic [cfm_pkg::PIX_W-1:0]  i_src,
    input  logic [cfm_pkg::PIX_W-1:0]  i_inc,
    output logic [cfm_pkg::OUT_W-1:0]  o_val
);
    import cfm_pkg::*;

    localparam int OW      = FRAC_BITS + 1;
    localparam int QB      = FRAC_BITS + 1;
    localparam int PW      = PIX_W + OW + 1;
    localparam int DVW     = 2 * FRAC_BITS + 24;
    localparam int EW      = QB + GAIN_W + 1;
    localparam int GN_W    = GAMMA_INDEX_BITS + 1;
    localparam int IW      = OW + GAMMA_INDEX_BITS + 1;
    localparam int S_DIV0  = 2;
    localparam int S_EXP   = QB + 2;
    localparam int S_SRCH0 = QB + 3;

    localparam logic [OW-1:0]   ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [GN_W-1:0] GN     = {1'b1, {GAMMA_INDEX_BITS{1'b0}}};
    localparam logic [PW-1:0]   HALF_P = PW'(1) << (FRAC_BITS - 1);
    localparam logic [EW-1:0]   HALF_E = EW'(1) << (FRAC_BITS - 1);
    localparam logic [IW-1:0]   HALF_I = IW'(1) << (FRAC_BITS - 1);
    localparam logic [DVW-1:0]  K20    = DVW'(20) << FRAC_BITS;
    localparam logic [DVW-1:0]  K40    = DVW'(40) << FRAC_BITS;
    localparam t_thr_tab        THR    = gamma_thr_tab(GAMMA_INDEX_BITS);

    // Cross-fade with rounding.
    logic [PW-1:0]    mix;
    logic [PIX_W-1:0] r_lin;

    assign mix = PW'(i_src) * PW'(ONE - i_weight) + PW'(i_inc) * PW'(i_weight) + HALF_P;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lin <= mix[FRAC_BITS +: PIX_W];
        end
    end

    // Tone-map numerator and denominator, both doubled for round half up.
    logic [DVW-1:0] den;
    logic [DVW-1:0] r_num;
    logic [DVW-1:0] r_den2;

    assign den = K20 + DVW'(r_lin) * DVW'(17);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_num  <= DVW'(r_lin) * K40 + den;
            r_den2 <= den << 1;
        end
    end

    // Restoring divider, one quotient bit per stage, most significant first.
    logic [DVW-1:0] r_drem [QB];
    logic [DVW-1:0] r_dden [QB];
    logic [QB-1:0]  r_dq   [QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [DVW-1:0] rem_in;
        logic [DVW-1:0] den_in;
        logic [QB-1:0]  q_in;
        logic [DVW-1:0] sh;
        logic [DVW-1:0] n_rem;
        logic [QB-1:0]  n_q;

        if (j == 0) begin : g_first
            assign rem_in = r_num;
            assign den_in = r_den2;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_drem[j-1];
            assign den_in = r_dden[j-1];
            assign q_in   = r_dq[j-1];
        end

        assign sh = den_in << (QB - 1 - j);

        always_comb begin
            n_rem = rem_in;
            n_q   = q_in;
            if (rem_in >= sh) begin
                n_rem             = rem_in - sh;
                n_q[QB - 1 - j]   = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[S_DIV0 + j]) begin
                r_drem[j] <= n_rem;
                r_dden[j] <= den_in;
                r_dq[j]   <= n_q;
            end
        end
    end

    // Exposure gain with saturation at one, then scaling to a gamma index.
    logic [EW-1:0]   exp_sum;
    logic [EW-1:0]   exp_full;
    logic [OW-1:0]   exp_val;
    logic [IW-1:0]   idx_sum;
    logic [IW-1:0]   idx_full;
    logic [GN_W-1:0] r_idx;

    assign exp_sum  = EW'(r_dq[QB-1]) * EW'(i_gain) + HALF_E;
    assign exp_full = exp_sum >> FRAC_BITS;
    assign exp_val  = (exp_full > EW'(ONE)) ? ONE : exp_full[OW-1:0];
    assign idx_sum  = {1'b0, exp_val, {GAMMA_INDEX_BITS{1'b0}}} + HALF_I;
    assign idx_full = idx_sum >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en[S_EXP]) begin
            r_idx <= (idx_full > IW'(GN)) ? GN : idx_full[GN_W-1:0];
        end
    end

    // Binary search for the largest code whose threshold the index reaches.
    logic [OUT_W-1:0] r_lo   [SRCH_STEPS];
    logic [OUT_W-1:0] r_hi   [SRCH_STEPS];
    logic [GN_W-1:0]  r_sidx [SRCH_STEPS];

    for (genvar s = 0; s < SRCH_STEPS; s++) begin : g_srch
        logic [OUT_W-1:0] lo_in;
        logic [OUT_W-1:0] hi_in;
        logic [GN_W-1:0]  idx_in;
        logic [OUT_W:0]   mid_sum;
        logic [OUT_W-1:0] mid;

        if (s == 0) begin : g_first
            assign lo_in  = '0;
            assign hi_in  = '1;
            assign idx_in = r_idx;
        end else begin : g_next
            assign lo_in  = r_lo[s-1];
            assign hi_in  = r_hi[s-1];
            assign idx_in = r_sidx[s-1];
        end

        assign mid_sum = (OUT_W+1)'(lo_in) + (OUT_W+1)'(hi_in) + (OUT_W+1)'(1);
        assign mid     = mid_sum[OUT_W:1];

        always_ff @(posedge i_clk) begin
            if (i_en[S_SRCH0 + s]) begin
                r_sidx[s] <= idx_in;
                if (THR_W'(idx_in) >= THR[mid]) begin
                    r_lo[s] <= mid;
                    r_hi[s] <= hi_in;
                end else begin
                    r_lo[s] <= lo_in;
                    r_hi[s] <= mid - OUT_W'(1);
                end
            end
        end
    end

    assign o_val = r_lo[SRCH_STEPS-1];

endmodule

// ===== verif/cfm_pixel_checker.sv =====
// Pixel checker: predicts each output pixel from the input beats and register writes.
`timescale 1ns / 100ps
module cfm_pixel_checker
    import cfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfm_pix_in_if       i_pix,
    cfm_pix_out_if      i_out,
    cfm_cfg_if          i_cfg,
    output int          o_err_count,
    output int          o_pending
);
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int GBITS = GAMMA_INDEX_BITS_DEF;
    localparam longint unsigned UNIT  = 64'd1 << FRAC;
    localparam longint unsigned GSPAN = 64'd1 << GBITS;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_rgb8;

    logic [OUT_W-1:0]  gamma_code [0:(1<<GBITS)];
    logic [MIX_W-1:0]  weight_q;
    logic [GAIN_W-1:0] gain_q;
    t_rgb8             expected_pixels [$];
    int                err_count;

    // True when gamma index idx is large enough to encode to code v.
    function automatic bit code_reached(int unsigned idx, int unsigned v);
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] rhs;
        lhs = BIG_W'(1);
        rhs = BIG_W'(1);
        for (int k = 0; k < 5; k++) lhs = lhs * BIG_W'(idx);
        for (int k = 0; k < 11; k++) lhs = lhs * BIG_W'(510);
        for (int k = 0; k < 11; k++) rhs = rhs * BIG_W'(2 * v - 1);
        rhs = rhs << (5 * GBITS);
        return lhs >= rhs;
    endfunction

    // Build the rounded gamma 1/2.2 table by searching the largest reached code.
    initial begin
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        for (int i = 0; i <= (1 << GBITS); i++) begin
            lo = 0;
            hi = 255;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (code_reached(i, mid)) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            gamma_code[i] = OUT_W'(lo);
        end
    end

    // Cross-fade, tone map, exposure, gamma encode of one color channel.
    function automatic logic [OUT_W-1:0] encode_channel(logic [PIX_W-1:0] src,
                                                        logic [PIX_W-1:0] inc);
        longint unsigned w;
        longint unsigned lin;
        longint unsigned num;
        longint unsigned den;
        longint unsigned mapped;
        longint unsigned exposed;
        longint unsigned idx;
        w = (weight_q > UNIT) ? UNIT : weight_q;
        lin = (src * (UNIT - w) + inc * w + UNIT / 2) >> FRAC;
        num = lin * 20 * UNIT;
        den = 20 * UNIT + 17 * lin;
        mapped = (2 * num + den) / (2 * den);
        exposed = (mapped * gain_q + UNIT / 2) >> FRAC;
        if (exposed > UNIT) exposed = UNIT;
        idx = (exposed * GSPAN + UNIT / 2) >> FRAC;
        if (idx > GSPAN) idx = GSPAN;
        return gamma_code[idx];
    endfunction

    // Track registers, queue predictions and compare output beats.
    always @(posedge i_clk) begin
        t_rgb8 got;
        t_rgb8 want;
        if (!i_rst_n) begin
            weight_q <= MIX_RST;
            gain_q   <= GAIN_RST;
            err_count = 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.idx))
                    CFG_MIX_WEIGHT:    weight_q <= i_cfg.data[MIX_W-1:0];
                    CFG_EXPOSURE_GAIN: gain_q <= i_cfg.data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                want.red   = encode_channel(i_pix.src_red, i_pix.inc_red);
                want.green = encode_channel(i_pix.src_green, i_pix.inc_green);
                want.blue  = encode_channel(i_pix.src_blue, i_pix.inc_blue);
                expected_pixels.push_back(want);
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.out_red, i_out.out_green, i_out.out_blue};
                if (expected_pixels.size() == 0) begin
                    if (err_count < 10) $display("unexpected output beat %h", got);
                    err_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        if (err_count < 10) begin
                            $display("pixel: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        end
                        err_count++;
                    end
                end
            end
        end
    end

    assign o_err_count = err_count;
    assign o_pending   = expected_pixels.size();
endmodule

// ===== verif/tb_crossfade_tone_map_gamma_pixel_unit.sv =====
// Testbench top: clock, reset, pixel and register stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module tb_crossfade_tone_map_gamma_pixel_unit;
    import cfm_pkg::*;

    localparam int SETTLE   = 40;
    localparam int WATCHDOG = 50000;

    logic i_clk;
    logic i_rst_n;
    int   err_count;
    int   pending;
    int   idle_cycles;
    bit   stall_free;

    cfm_pix_in_if  pix_in ();
    cfm_pix_out_if pix_out ();
    cfm_cfg_if     cfg ();

    crossfade_tone_map_gamma_pixel_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_in),
        .o_pix  (pix_out),
        .i_cfg  (cfg)
    );

    cfm_pixel_checker checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_in),
        .i_out      (pix_out),
        .i_cfg      (cfg),
        .o_err_count(err_count),
        .o_pending  (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (stall_free || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Linear value biased toward the interesting corners of Q4.12.
    function automatic logic [PIX_W-1:0] linear_val();
        case ($urandom_range(0, 4))
            0: return PIX_W'($urandom);
            1: return PIX_W'($urandom_range(0, 8192));
            2: return PIX_W'($urandom_range(0, 255));
            3: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return PIX_W'(4096);
                endcase
            end
            default: return PIX_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Drive one pixel beat, wait for it to be taken, then maybe idle.
    task automatic send_pixel(logic [PIX_W-1:0] sr, logic [PIX_W-1:0] sg,
                              logic [PIX_W-1:0] sb, logic [PIX_W-1:0] ir,
                              logic [PIX_W-1:0] ig, logic [PIX_W-1:0] ib);
        int gap;
        pix_in.valid     <= 1'b1;
        pix_in.src_red   <= sr;
        pix_in.src_green <= sg;
        pix_in.src_blue  <= sb;
        pix_in.inc_red   <= ir;
        pix_in.inc_green <= ig;
        pix_in.inc_blue  <= ib;
        do @(posedge i_clk); while (!pix_in.ready);
        gap = gap_len();
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random_pixel();
        send_pixel(linear_val(), linear_val(), linear_val(),
                   linear_val(), linear_val(), linear_val());
    endtask

    // Drain the pipeline, then write one register.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.idx   <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Write to an index that holds no register; the unit drops it.
    task automatic write_unused(logic [CFG_IDX_W-1:0] idx);
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.idx   <= idx;
        cfg.data  <= CFG_DATA_W'($urandom);
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // Random output stalls in bursts, with stall-free stretches.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!i_rst_n || stall_free) begin
            pix_out.ready <= 1'b1;
        end else if (!pix_out.ready) begin
            pix_out.ready <= (r < 35);
        end else if (r < 3) begin
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= (r >= 20);
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
            (cfg.valid && cfg.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("crossfade_tone_map_gamma_pixel_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [MIX_W-1:0]  weights [6];
        logic [GAIN_W-1:0] gains [6];
        stall_free       = 1'b0;
        i_rst_n          = 1'b0;
        pix_in.valid     = 1'b0;
        pix_in.src_red   = '0;
        pix_in.src_green = '0;
        pix_in.src_blue  = '0;
        pix_in.inc_red   = '0;
        pix_in.inc_green = '0;
        pix_in.inc_blue  = '0;
        cfg.valid        = 1'b0;
        cfg.idx          = '0;
        cfg.data         = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, field extremes, black, white and unity.
        send_pixel('0, '0, '0, '0, '0, '0);
        send_pixel('1, '1, '1, '1, '1, '1);
        send_pixel(16'd4096, 16'd4096, 16'd4096, '0, '0, '0);
        send_pixel(16'd1, 16'd2, 16'd3, '1, '1, '1);
        send_pixel(16'h5555, 16'hAAAA, 16'h8000, 16'hAAAA, 16'h5555, 16'h7FFF);
        // Full weight on the incoming frame.
        write_reg(CFG_MIX_WEIGHT, 16'd4096);
        send_pixel('1, '1, '1, '0, '0, '0);
        send_pixel('0, '0, '0, 16'd4096, 16'd1, '1);
        // Weight above one clamps to one; unmasked upper data bits are dropped.
        write_reg(CFG_MIX_WEIGHT, 16'hFFFF);
        send_pixel('1, 16'd4096, '0, 16'd2048, 16'd100, 16'd1);
        // Huge exposure saturates; zero exposure gives black.
        write_reg(CFG_EXPOSURE_GAIN, 16'hFFFF);
        send_pixel(16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd16);
        send_pixel('1, '1, '1, '1, '1, '1);
        write_reg(CFG_EXPOSURE_GAIN, 16'd0);
        send_pixel('1, '1, '1, '1, '1, '1);
        write_unused(2'd2);
        write_unused(2'd3);
        send_pixel(16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0, 16'h8001, 16'h00FF);
        write_reg(CFG_MIX_WEIGHT, 16'd2048);
        write_reg(CFG_EXPOSURE_GAIN, 16'd4096);
        send_pixel('1, 16'd4096, '0, '0, 16'd4096, '1);
        send_pixel(16'd8192, 16'd12288, 16'd40000, 16'd8191, 16'd1, 16'd0);

        // Random phases over a sweep of register settings.
        weights = '{13'd0, 13'd4096, 13'd8191, 13'd1, 13'd2048, 13'd3000};
        gains   = '{16'd4096, 16'd65535, 16'd1, 16'd8192, 16'd2048, 16'd12000};
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 6) begin
                write_reg(CFG_MIX_WEIGHT, {3'b000, weights[ph]});
                write_reg(CFG_EXPOSURE_GAIN, gains[ph]);
            end else begin
                write_reg(CFG_MIX_WEIGHT, CFG_DATA_W'($urandom));
                write_reg(CFG_EXPOSURE_GAIN, CFG_DATA_W'($urandom));
            end
            stall_free = (ph == 2);
            for (int n = 0; n < 135; n++) begin
                send_random_pixel();
            end
        end
        stall_free = 1'b0;

        // Drain and give the verdict.
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("crossfade_tone_map_gamma_pixel_unit: match");
        end else begin
            $display("crossfade_tone_map_gamma_pixel_unit: mismatch");
        end
        $finish;
    end
endmodule
